// File: rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared widths, register reset values and types of the D3Q7 cell collision.
// ----------------------------------------------------------------------------
package lcc_pkg;

   // Number of lattice directions: rest plus six moving directions.
   localparam int NUM_DIR = 7;

   // Field widths.
   localparam int DIST_W = 32;   // Q16.16 distribution
   localparam int GAIN_W = 16;   // Q4.12 gain
   localparam int RHO_W  = 35;   // exact sum of seven distributions
   localparam int MOM_W  = 33;   // exact difference of an opposite pair
   localparam int EQ_W   = 40;   // rounded equilibrium, held wide
   localparam int FRAC_G = 12;   // fraction bits of a gain

   // Reset values of the gain registers (Q4.12).
   localparam logic signed [GAIN_W-1:0] KEEP_GAIN_RST = -16'sd4096;
   localparam logic signed [GAIN_W-1:0] PULL_GAIN_RST = 16'sd8192;
   localparam logic signed [GAIN_W-1:0] REST_GAIN_RST = 16'sd3328;
   localparam logic signed [GAIN_W-1:0] MOVE_GAIN_RST = 16'sd128;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_KEEP_GAIN = 2'd0,
      REG_PULL_GAIN = 2'd1,
      REG_REST_GAIN = 2'd2,
      REG_MOVE_GAIN = 2'd3
   } lcc_reg_type;

   // Control that travels with a cell into the mixing lanes.
   typedef struct packed {
      logic valid;
      logic force_src;
   } lcc_mix_ctl_type;

endpackage

// File: rtl/lattice_cell_collision.sv
// ----------------------------------------------------------------------------
// lattice_cell_collision
// BGK collision of one D3Q7 lattice cell in Q16.16 with Q4.12 gains.
// ----------------------------------------------------------------------------
// The block takes one cell in every clock cycle: busy is always low, so a
// transfer happens whenever start is high. Each cell's result appears on the
// rsp_ ports once it has passed the six register stages, for one cycle only,
// marked by rsp_valid; the receiver has no way to hold results off and must take each one then. The six
// register stages are the input register, the density and momentum sums, the
// density-by-gain multiplies, the equilibrium rounding, the relaxation
// multiplies and the final round and saturate. The gains are read live, so
// write them only while no cell is in flight.
module lattice_cell_collision (
   input  logic                                  clock,
   input  logic                                  reset,
   // Cell input
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_dist_rest,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_dist_xpos,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_dist_xneg,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_dist_ypos,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_dist_yneg,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_dist_zpos,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_dist_zneg,
   input  logic                                  req_force_source,
   input  logic signed [lcc_pkg::DIST_W-1:0]     req_source_density,
   // Result output
   output logic                                  rsp_valid,
   output logic signed [lcc_pkg::DIST_W-1:0]     rsp_new_rest,
   output logic signed [lcc_pkg::DIST_W-1:0]     rsp_new_xpos,
   output logic signed [lcc_pkg::DIST_W-1:0]     rsp_new_xneg,
   output logic signed [lcc_pkg::DIST_W-1:0]     rsp_new_ypos,
   output logic signed [lcc_pkg::DIST_W-1:0]     rsp_new_yneg,
   output logic signed [lcc_pkg::DIST_W-1:0]     rsp_new_zpos,
   output logic signed [lcc_pkg::DIST_W-1:0]     rsp_new_zneg,
   // Configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [3:0]                            paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int N     = lcc_pkg::NUM_DIR;
   localparam int DW    = lcc_pkg::DIST_W;
   localparam int GW    = lcc_pkg::GAIN_W;
   localparam int PR_W  = lcc_pkg::RHO_W + GW;       // density product
   localparam int RS_W  = PR_W + 1;                  // product plus rounding
   localparam int MV_W  = RS_W - lcc_pkg::FRAC_G;    // rounded product

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic signed [GW-1:0]   keep_gain_ff;
   logic signed [GW-1:0]   pull_gain_ff;
   logic signed [GW-1:0]   rest_gain_ff;
   logic signed [GW-1:0]   move_gain_ff;
   logic                   csr_wr;
   lcc_pkg::lcc_reg_type   csr_reg;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_reg = lcc_pkg::lcc_reg_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_gain_ff <= lcc_pkg::KEEP_GAIN_RST;
         pull_gain_ff <= lcc_pkg::PULL_GAIN_RST;
         rest_gain_ff <= lcc_pkg::REST_GAIN_RST;
         move_gain_ff <= lcc_pkg::MOVE_GAIN_RST;
      end else if (csr_wr) begin
         unique case (csr_reg)
            lcc_pkg::REG_KEEP_GAIN: keep_gain_ff <= pwdata[GW-1:0];
            lcc_pkg::REG_PULL_GAIN: pull_gain_ff <= pwdata[GW-1:0];
            lcc_pkg::REG_REST_GAIN: rest_gain_ff <= pwdata[GW-1:0];
            lcc_pkg::REG_MOVE_GAIN: move_gain_ff <= pwdata[GW-1:0];
         endcase
      end
   end

   // Read back, sign-extended to the bus width.
   always_comb begin
      unique case (csr_reg)
         lcc_pkg::REG_KEEP_GAIN: prdata = 32'(keep_gain_ff);
         lcc_pkg::REG_PULL_GAIN: prdata = 32'(pull_gain_ff);
         lcc_pkg::REG_REST_GAIN: prdata = 32'(rest_gain_ff);
         lcc_pkg::REG_MOVE_GAIN: prdata = 32'(move_gain_ff);
      endcase
   end

   // ------------------------------------------------------------------------
   // Valid chain: one bit per stage, the last one is the result strobe.
   // ------------------------------------------------------------------------
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff, valid6_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else begin
         valid1_ff <= start & ~busy;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
      end
   end

   assign rsp_valid = valid6_ff;

   // ------------------------------------------------------------------------
   // Stage 1: input register.
   // ------------------------------------------------------------------------
   logic signed [DW-1:0] dist_in  [N];
   logic signed [DW-1:0] dist1_ff [N];
   logic                 force1_ff;
   logic signed [DW-1:0] src1_ff;

   assign dist_in[0] = req_dist_rest;
   assign dist_in[1] = req_dist_xpos;
   assign dist_in[2] = req_dist_xneg;
   assign dist_in[3] = req_dist_ypos;
   assign dist_in[4] = req_dist_yneg;
   assign dist_in[5] = req_dist_zpos;
   assign dist_in[6] = req_dist_zneg;

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         dist1_ff  <= dist_in;
         force1_ff <= req_force_source;
         src1_ff   <= req_source_density;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: density (or the source density) and momenta, exact.
   // ------------------------------------------------------------------------
   logic signed [lcc_pkg::RHO_W-1:0] rho_sum;
   logic signed [lcc_pkg::RHO_W-1:0] rho2_in;
   logic signed [lcc_pkg::RHO_W-1:0] rho2_ff;
   logic signed [lcc_pkg::MOM_W-1:0] mom2_in [3];
   logic signed [lcc_pkg::MOM_W-1:0] mom2_ff [3];
   logic signed [DW-1:0]             dist2_ff [N];
   logic                             force2_ff;

   always_comb begin
      rho_sum = '0;
      for (int i = 0; i < N; i++) begin
         rho_sum = rho_sum + lcc_pkg::RHO_W'(dist1_ff[i]);
      end
      rho2_in = force1_ff ? lcc_pkg::RHO_W'(src1_ff) : rho_sum;
      for (int a = 0; a < 3; a++) begin
         mom2_in[a] = lcc_pkg::MOM_W'(dist1_ff[2*a+1])
                    - lcc_pkg::MOM_W'(dist1_ff[2*a+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (valid1_ff) begin
         rho2_ff   <= rho2_in;
         mom2_ff   <= mom2_in;
         dist2_ff  <= dist1_ff;
         force2_ff <= force1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: density times the rest and move gains.
   // ------------------------------------------------------------------------
   logic signed [PR_W-1:0]           rest_prod3_ff;
   logic signed [PR_W-1:0]           move_prod3_ff;
   logic signed [lcc_pkg::MOM_W-1:0] mom3_ff [3];
   logic signed [DW-1:0]             dist3_ff [N];
   logic                             force3_ff;

   always_ff @(posedge clock) begin
      if (valid2_ff) begin
         rest_prod3_ff <= PR_W'(rho2_ff) * PR_W'(rest_gain_ff);
         move_prod3_ff <= PR_W'(rho2_ff) * PR_W'(move_gain_ff);
         mom3_ff       <= mom2_ff;
         dist3_ff      <= dist2_ff;
         force3_ff     <= force2_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: round half up to Q16.16 and build the seven equilibria.
   // ------------------------------------------------------------------------
   logic signed [RS_W-1:0]          rest_rs;
   logic signed [RS_W-1:0]          move_rs;
   logic signed [MV_W-1:0]          rest_rnd;
   logic signed [MV_W-1:0]          move_rnd;
   logic signed [lcc_pkg::EQ_W-1:0] eq4_in [N];
   logic signed [lcc_pkg::EQ_W-1:0] eq4_ff [N];
   logic signed [DW-1:0]            dist4_ff [N];
   logic                            force4_ff;

   always_comb begin
      rest_rs  = RS_W'(rest_prod3_ff) + RS_W'(1 <<< (lcc_pkg::FRAC_G - 1));
      move_rs  = RS_W'(move_prod3_ff) + RS_W'(1 <<< (lcc_pkg::FRAC_G - 1));
      rest_rnd = rest_rs[RS_W-1:lcc_pkg::FRAC_G];
      move_rnd = move_rs[RS_W-1:lcc_pkg::FRAC_G];
      eq4_in[0] = lcc_pkg::EQ_W'(rest_rnd);
      for (int a = 0; a < 3; a++) begin
         eq4_in[2*a+1] = lcc_pkg::EQ_W'(move_rnd) + lcc_pkg::EQ_W'(mom3_ff[a]);
         eq4_in[2*a+2] = lcc_pkg::EQ_W'(move_rnd) - lcc_pkg::EQ_W'(mom3_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (valid3_ff) begin
         eq4_ff    <= eq4_in;
         dist4_ff  <= dist3_ff;
         force4_ff <= force3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stages 5 and 6: relaxation lanes, one per direction.
   // ------------------------------------------------------------------------
   lcc_pkg::lcc_mix_ctl_type mix_ctl;
   logic signed [DW-1:0]     new_dist [N];

   assign mix_ctl.valid     = valid4_ff;
   assign mix_ctl.force_src = force4_ff;

   for (genvar g = 0; g < N; g++) begin : g_lane
      lcc_dir_mix u_mix (
         .clock     (clock),
         .mix_ctl   (mix_ctl),
         .keep_gain (keep_gain_ff),
         .pull_gain (pull_gain_ff),
         .old_dist  (dist4_ff[g]),
         .eq        (eq4_ff[g]),
         .new_dist  (new_dist[g])
      );
   end

   assign rsp_new_rest = new_dist[0];
   assign rsp_new_xpos = new_dist[1];
   assign rsp_new_xneg = new_dist[2];
   assign rsp_new_ypos = new_dist[3];
   assign rsp_new_yneg = new_dist[4];
   assign rsp_new_zpos = new_dist[5];
   assign rsp_new_zneg = new_dist[6];

endmodule

// File: rtl/lcc_dir_mix.sv
// ----------------------------------------------------------------------------
// lcc_dir_mix
// One direction's relaxation: keep * old + pull * equilibrium, rounded half up
// to Q16.16 and saturated, or the saturated equilibrium for a source cell.
// ----------------------------------------------------------------------------
module lcc_dir_mix (
   input  logic                                     clock,
   input  lcc_pkg::lcc_mix_ctl_type                 mix_ctl,
   input  logic signed [lcc_pkg::GAIN_W-1:0]        keep_gain,
   input  logic signed [lcc_pkg::GAIN_W-1:0]        pull_gain,
   input  logic signed [lcc_pkg::DIST_W-1:0]        old_dist,
   input  logic signed [lcc_pkg::EQ_W-1:0]          eq,
   output logic signed [lcc_pkg::DIST_W-1:0]        new_dist
);

   localparam int KP_W  = lcc_pkg::GAIN_W + lcc_pkg::DIST_W;  // keep product
   localparam int PP_W  = lcc_pkg::GAIN_W + lcc_pkg::EQ_W;    // pull product
   localparam int SUM_W = PP_W + 1;
   localparam int RND_W = SUM_W - lcc_pkg::FRAC_G;

   // Saturate a wide value to the signed 32-bit range.
   function automatic logic signed [lcc_pkg::DIST_W-1:0] sat_dist(
      input logic signed [RND_W-1:0] x
   );
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] lo;
      hi = RND_W'({1'b0, {(lcc_pkg::DIST_W-1){1'b1}}});
      lo = -hi - RND_W'(1);
      if (x > hi) begin
         return {1'b0, {(lcc_pkg::DIST_W-1){1'b1}}};
      end else if (x < lo) begin
         return {1'b1, {(lcc_pkg::DIST_W-1){1'b0}}};
      end
      return x[lcc_pkg::DIST_W-1:0];
   endfunction

   logic signed [KP_W-1:0]             keep_prod_ff;
   logic signed [KP_W-1:0]             keep_prod_in;
   logic signed [PP_W-1:0]             pull_prod_ff;
   logic signed [PP_W-1:0]             pull_prod_in;
   logic signed [lcc_pkg::DIST_W-1:0]  eq_sat_ff;
   logic signed [lcc_pkg::DIST_W-1:0]  eq_sat_in;
   logic                               force_ff;
   logic signed [SUM_W-1:0]            mix_sum;
   logic signed [RND_W-1:0]            mix_rnd;
   logic signed [lcc_pkg::DIST_W-1:0]  new_dist_ff;
   logic signed [lcc_pkg::DIST_W-1:0]  new_dist_in;

   // Multiply stage: both weighted terms and the clipped equilibrium.
   assign keep_prod_in = KP_W'(keep_gain) * KP_W'(old_dist);
   assign pull_prod_in = PP_W'(pull_gain) * PP_W'(eq);
   assign eq_sat_in    = sat_dist(RND_W'(eq));

   always_ff @(posedge clock) begin
      if (mix_ctl.valid) begin
         keep_prod_ff <= keep_prod_in;
         pull_prod_ff <= pull_prod_in;
         eq_sat_ff    <= eq_sat_in;
         force_ff     <= mix_ctl.force_src;
      end
   end

   // Sum, round half up to Q16.16 and clip.
   always_comb begin
      mix_sum = SUM_W'(keep_prod_ff) + SUM_W'(pull_prod_ff)
              + SUM_W'(1 <<< (lcc_pkg::FRAC_G - 1));
      mix_rnd = mix_sum[SUM_W-1:lcc_pkg::FRAC_G];
      if (force_ff) begin
         new_dist_in = eq_sat_ff;
      end else begin
         new_dist_in = sat_dist(mix_rnd);
      end
   end

   always_ff @(posedge clock) begin
      new_dist_ff <= new_dist_in;
   end

   assign new_dist = new_dist_ff;

endmodule
